### rtl/core/chc_pkg.sv
// Shared types and constants for the compass heading correction filter.
package chc_pkg;

    localparam int NUM_DIRS     = 8;
    localparam int CFG_REGS     = NUM_DIRS / 2 + 1;
    localparam int CFG_IDX_W    = $clog2(CFG_REGS);
    localparam int CFG_DATA_W   = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 34;
    localparam int CNT_W        = 6;
    localparam int HEAD_FULL    = 3600;
    localparam int HEAD_HALF    = 1800;
    localparam int DIR_STEP     = 450;
    localparam int CORR_MIN     = -1024;
    localparam int CORR_MAX     = 4607;
    localparam int GAIN_RESET   = 32768;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(NUM_DIRS / 2);

    // Commands from the sequencer to the datapath, one phase per flag.
    typedef struct packed {
        logic       load;
        logic       cordic;
        logic       head;
        logic       sector;
        logic       prep;
        logic       mulb;
        logic       nums;
        logic       div_init;
        logic       div_step;
        logic       sat;
        logic       fmul;
        logic       commit;
        logic [3:0] step;
    } chc_cmd_t;

    // Arctangent of 2^-i in units of 1/65536 tenth-degree.
    function automatic logic signed [28:0] atan_val(input logic [3:0] idx);
        logic signed [28:0] v;
        unique case (idx)
            4'd0:  v = 29'sd29491200;
            4'd1:  v = 29'sd17409672;
            4'd2:  v = 29'sd9198793;
            4'd3:  v = 29'sd4669451;
            4'd4:  v = 29'sd2343787;
            4'd5:  v = 29'sd1173036;
            4'd6:  v = 29'sd586661;
            4'd7:  v = 29'sd293348;
            4'd8:  v = 29'sd146676;
            4'd9:  v = 29'sd73339;
            4'd10: v = 29'sd36669;
            4'd11: v = 29'sd18335;
            4'd12: v = 29'sd9167;
            4'd13: v = 29'sd4584;
            4'd14: v = 29'sd2292;
            4'd15: v = 29'sd1146;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/chc_datapath.sv
// Datapath: CORDIC, sector correction, divider and circular low-pass filter.
module chc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  chc_pkg::chc_cmd_t               cmd,
    input  logic                            cfg_write_en,
    input  logic [chc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [15:0]              mag_x,
    input  logic signed [15:0]              mag_y,
    output logic [11:0]                     filtered_heading,
    output logic signed [13:0]              corrected_heading
);
    import chc_pkg::*;

    logic [31:0]        offset_reg [NUM_DIRS/2];
    logic [15:0]        gain_reg;
    logic [11:0]        mem_reg;
    logic signed [19:0] cx_reg, cy_reg;
    logic signed [28:0] z_reg;
    logic               skip_reg, xneg_reg, yneg_reg;
    logic [11:0]        h_reg;
    logic signed [17:0] hs_reg;
    logic [2:0]         k_reg;
    logic signed [17:0] den_reg;
    logic signed [19:0] w_reg;
    logic [11:0]        base_reg;
    logic signed [33:0] p1_reg, num_reg;
    logic [33:0]        n_reg;
    logic [16:0]        d_reg, rem_reg;
    logic               neg_reg, dz_reg;
    logic signed [13:0] corr_reg, corr_out_reg;
    logic signed [32:0] prod_reg;

    logic signed [17:0] dofs [NUM_DIRS];

    // Unpack the sector offsets.
    always_comb
    begin
        for (int i = 0; i < NUM_DIRS; i++)
        begin
            dofs[i] = 18'(signed'(offset_reg[i/2][(i%2)*16 +: 16]));
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIRS/2; i++)
            begin
                offset_reg[i] <= '0;
            end
            gain_reg <= 16'(GAIN_RESET);
        end
        else if (cfg_write_en)
        begin
            if (cfg_index < REG_GAIN)
            begin
                offset_reg[cfg_index[CFG_IDX_W-2:0]] <= cfg_data;
            end
            else if (cfg_index == REG_GAIN)
            begin
                gain_reg <= cfg_data[15:0];
            end
        end
    end

    // Load and CORDIC vectoring step.
    logic [16:0]        ax, ay;
    logic signed [16:0] xv;
    logic signed [19:0] dx, dy;
    logic signed [28:0] tabv;

    always_comb
    begin
        xv   = (mag_x == 16'sd0) ? 17'sd1 : 17'(mag_x);
        ax   = xv[16] ? 17'(-xv) : 17'(xv);
        ay   = mag_y[15] ? 17'(-17'(mag_y)) : 17'(mag_y);
        dx   = cy_reg >>> cmd.step;
        dy   = cx_reg >>> cmd.step;
        tabv = atan_val(cmd.step);
    end

    // Heading from the angle.
    logic signed [28:0] zc, m;
    logic [10:0]        t;
    logic signed [12:0] hn;

    always_comb
    begin
        zc = z_reg[28] ? 29'sd0 : z_reg;
        m  = xneg_reg ? (29'(HEAD_HALF * 65536) - zc) : zc;
        if (m[28])
        begin
            m = '0;
        end
        t  = m[26:16];
        hn = yneg_reg ? 13'(t) : -13'(t);
        if (hn[12])
        begin
            hn = hn + 13'(HEAD_FULL);
        end
    end

    // Sector search.
    logic signed [17:0] hz, hs_n;
    logic [2:0]         k_n;

    always_comb
    begin
        hz   = 18'(h_reg);
        hs_n = hz;
        k_n  = 3'(NUM_DIRS - 1);
        if (hz < -dofs[0])
        begin
            hs_n = hz + 18'(HEAD_FULL);
        end
        else if (hz < 18'(HEAD_FULL - DIR_STEP) - dofs[NUM_DIRS-1])
        begin
            k_n = 3'(NUM_DIRS - 2);
            for (int i = NUM_DIRS - 2; i >= 1; i--)
            begin
                if (hz < 18'(DIR_STEP * i) - dofs[i])
                begin
                    k_n = 3'(i - 1);
                end
            end
        end
    end

    // Divider step and magnitudes.
    logic [17:0] rem_sh;
    logic        qbit;
    logic signed [34:0] qs, cand;

    always_comb
    begin
        rem_sh = {rem_reg, n_reg[33]};
        qbit   = (rem_sh >= {1'b0, d_reg});
        qs     = neg_reg ? -35'(n_reg) : 35'(n_reg);
        cand   = dz_reg ? 35'(hs_reg) : qs;
    end

    // Filter arithmetic.
    logic signed [15:0] diff;
    logic signed [32:0] qf_w;
    logic signed [16:0] s;

    always_comb
    begin
        diff = 16'(corr_reg) - 16'(mem_reg);
        if (diff > 16'sd1800)
        begin
            diff = diff - 16'(HEAD_FULL);
        end
        else if (diff < -16'sd1800)
        begin
            diff = diff + 16'(HEAD_FULL);
        end
        qf_w = prod_reg[32] ? ((prod_reg + 33'sd32767) >>> 15) : (prod_reg >>> 15);
        s    = 17'(mem_reg) + 17'($signed(qf_w[15:0]));
        if (s >= 17'sd7200)
        begin
            s = s - 17'sd7200;
        end
        if (s >= 17'(HEAD_FULL))
        begin
            s = s - 17'(HEAD_FULL);
        end
        if (s < -17'(HEAD_FULL))
        begin
            s = s + 17'sd7200;
        end
        if (s < 0)
        begin
            s = s + 17'(HEAD_FULL);
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg   <= 20'(ax);
            cy_reg   <= 20'(ay);
            xneg_reg <= xv[16];
            yneg_reg <= mag_y[15];
            skip_reg <= (ay == 17'd0) || (ax == ay);
            z_reg    <= (ay != 17'd0 && ax == ay) ? atan_val(4'd0) : 29'sd0;
        end
        if (cmd.cordic && !skip_reg)
        begin
            if (!cy_reg[19])
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + tabv;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - tabv;
            end
        end
        if (cmd.head)
        begin
            h_reg <= 12'(hn);
        end
        if (cmd.sector)
        begin
            hs_reg <= hs_n;
            k_reg  <= k_n;
        end
        if (cmd.prep)
        begin
            den_reg  <= 18'(DIR_STEP) + dofs[k_reg] - dofs[3'(k_reg + 3'd1)];
            w_reg    <= 20'(hs_reg) - 20'(k_reg * 12'(DIR_STEP)) + 20'(dofs[k_reg]);
            base_reg <= 12'(k_reg * 12'(DIR_STEP));
        end
        if (cmd.mulb)
        begin
            p1_reg <= 34'($signed({1'b0, base_reg}) * den_reg);
        end
        if (cmd.nums)
        begin
            num_reg <= p1_reg + 34'(w_reg * 20'sd450);
        end
        if (cmd.div_init)
        begin
            n_reg   <= num_reg[33] ? 34'(-num_reg) : 34'(num_reg);
            d_reg   <= den_reg[17] ? 17'(-den_reg) : 17'(den_reg);
            rem_reg <= '0;
            neg_reg <= num_reg[33] ^ den_reg[17];
            dz_reg  <= (den_reg == 18'sd0);
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? 17'(rem_sh - {1'b0, d_reg}) : rem_sh[16:0];
            n_reg   <= {n_reg[32:0], qbit};
        end
        if (cmd.sat)
        begin
            if (cand < 35'(CORR_MIN))
            begin
                corr_reg <= 14'(CORR_MIN);
            end
            else if (cand > 35'(CORR_MAX))
            begin
                corr_reg <= 14'(CORR_MAX);
            end
            else
            begin
                corr_reg <= 14'(cand);
            end
        end
        if (cmd.fmul)
        begin
            prod_reg <= 33'(diff * $signed({1'b0, gain_reg}));
        end
        if (cmd.commit)
        begin
            corr_out_reg <= corr_reg;
        end
    end

    // Filter memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_reg <= '0;
        end
        else if (cmd.commit)
        begin
            mem_reg <= 12'(s);
        end
    end

    assign filtered_heading  = mem_reg;
    assign corrected_heading = corr_out_reg;

    // The filter memory always holds a heading in range.
    a_mem_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_reg < 12'(HEAD_FULL))
        else $error("filter memory out of range");

endmodule

### rtl/core/chc_ctrl.sv
// Sequencer that steps the datapath through one sample and owns the handshakes.
module chc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output chc_pkg::chc_cmd_t cmd
);
    import chc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CORD, S_HEAD, S_SECT, S_PREP, S_MULB, S_NUMS,
        S_DIVI, S_DIVS, S_SATS, S_FMUL, S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic               commit;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign commit    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Command decode.
    always_comb
    begin
        cmd          = '0;
        cmd.step     = cnt_reg[3:0];
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.cordic   = (state_reg == S_CORD);
        cmd.head     = (state_reg == S_HEAD);
        cmd.sector   = (state_reg == S_SECT);
        cmd.prep     = (state_reg == S_PREP);
        cmd.mulb     = (state_reg == S_MULB);
        cmd.nums     = (state_reg == S_NUMS);
        cmd.div_init = (state_reg == S_DIVI);
        cmd.div_step = (state_reg == S_DIVS);
        cmd.sat      = (state_reg == S_SATS);
        cmd.fmul     = (state_reg == S_FMUL);
        cmd.commit   = commit;
    end

    // State, step counter and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= S_CORD;
                    end
                end
                S_CORD:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD: state_reg <= S_SECT;
                S_SECT: state_reg <= S_PREP;
                S_PREP: state_reg <= S_MULB;
                S_MULB: state_reg <= S_NUMS;
                S_NUMS: state_reg <= S_DIVI;
                S_DIVI:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIVS;
                end
                S_DIVS:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_SATS;
                    end
                end
                S_SATS: state_reg <= S_FMUL;
                S_FMUL: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (commit)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // A result is only committed when the output register is free.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over an untaken beat");

    // An accepted beat starts the CORDIC.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CORD))
        else $error("accepted beat did not start the CORDIC");

    // The divider runs exactly its step count.
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVS && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=> (state_reg == S_SATS))
        else $error("divider step count wrong");

    // A commit always raises the result valid flag.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("commit did not present a result");

endmodule

### rtl/core/compass_heading_correct_filter_core.sv
// Top level of the compass heading correction filter.
// Each accepted X/Y beat yields one result beat of filtered and corrected heading
// in tenths of a degree. The result beat is presented after the 16-step CORDIC
// and the 34-step restoring divider, which share one sequencer; a new sample is
// taken once the previous one has reached the output register, even if that
// result is still waiting, so the core does not accept a new sample until it is
// through with the last one. Offsets and gain must be written through the
// configuration port only while idle; the block itself does not enforce this.
module compass_heading_correct_filter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [15:0]              mag_x,
    input  logic signed [15:0]              mag_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [11:0]                     filtered_heading,
    output logic signed [13:0]              corrected_heading,
    input  logic                            cfg_write_en,
    input  logic [chc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import chc_pkg::*;

    chc_cmd_t cmd;

    chc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    chc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mag_x             (mag_x),
        .mag_y             (mag_y),
        .filtered_heading  (filtered_heading),
        .corrected_heading (corrected_heading)
    );

endmodule

### bench/tb_top.sv
// Self-checking testbench for the compass heading correction filter.
module tb_top;
    import chc_pkg::*;

    localparam int PERIOD     = 12;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 80;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OFS01  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFS23  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFS45  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OFS67  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(5);

    // Heading predictor and store of expected headings.
    class heading_board;
        logic [31:0]        ofs_reg [NUM_DIRS/2];
        logic [15:0]        gain;
        longint             memory;
        logic [11:0]        exp_filt [$];
        logic signed [13:0] exp_corr [$];
        int                 errors;

        function new();
            foreach (ofs_reg[i]) ofs_reg[i] = '0;
            gain   = 16'(GAIN_RESET);
            memory = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx < REG_GAIN)
                ofs_reg[idx] = data;
            else if (idx == REG_GAIN)
                gain = data[15:0];
        endfunction

        function longint dir_ofs(int i);
            logic [31:0] r;
            logic signed [15:0] v;
            r = ofs_reg[(i / 2) % (NUM_DIRS / 2)];
            v = (i % 2) ? r[31:16] : r[15:0];
            return longint'(v);
        endfunction

        // Clockwise heading from CORDIC vectoring, 0..3599.
        function longint compass_raw(longint x, longint y);
            longint ax, ay, z, cx, cy, dx, dy, m, h;
            if (x == 0) x = 1;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            z = 0;
            if (ay == 0)
                z = 0;
            else if (ax == ay)
                z = longint'(atan_val(4'd0));
            else begin
                cx = ax;
                cy = ay;
                for (int i = 0; i < CORDIC_STEPS; i++) begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (cy >= 0) begin
                        cx += dx; cy -= dy; z += longint'(atan_val(4'(i)));
                    end else begin
                        cx -= dx; cy += dy; z -= longint'(atan_val(4'(i)));
                    end
                end
            end
            if (z < 0) z = 0;
            m = x < 0 ? longint'(HEAD_HALF) * 65536 - z : z;
            if (m < 0) m = 0;
            h = (y >= 0) ? -(m >>> 16) : (m >>> 16);
            if (h < 0) h += HEAD_FULL;
            return h;
        endfunction

        // Sector search and piecewise-linear calibration, saturated.
        function longint calibrate(longint h);
            int k;
            longint den, base, c;
            if (h < -dir_ofs(0)) begin
                k = NUM_DIRS - 1;
                h += HEAD_FULL;
            end else if (h < HEAD_FULL - DIR_STEP - dir_ofs(NUM_DIRS - 1)) begin
                k = NUM_DIRS - 2;
                for (int i = 1; i < NUM_DIRS - 1; i++)
                    if (h < DIR_STEP * i - dir_ofs(i)) begin
                        k = i - 1;
                        break;
                    end
            end else
                k = NUM_DIRS - 1;
            den = DIR_STEP + dir_ofs(k) - dir_ofs((k + 1) % NUM_DIRS);
            if (den == 0)
                c = h;
            else begin
                base = longint'(DIR_STEP) * k;
                c = (base * den + DIR_STEP * (h - base + dir_ofs(k))) / den;
            end
            if (c < CORR_MIN) c = CORR_MIN;
            if (c > CORR_MAX) c = CORR_MAX;
            return c;
        endfunction

        function void note_sample(logic signed [15:0] x, logic signed [15:0] y);
            longint c, diff, s;
            c = calibrate(compass_raw(longint'(x), longint'(y)));
            diff = c - memory;
            if (diff > HEAD_HALF) diff -= HEAD_FULL;
            else if (diff < -HEAD_HALF) diff += HEAD_FULL;
            s = (memory + (diff * longint'(gain)) / GAIN_RESET) % HEAD_FULL;
            if (s < 0) s += HEAD_FULL;
            memory = s;
            exp_filt.push_back(12'(s));
            exp_corr.push_back(14'(c));
        endfunction

        function void check_result(logic [11:0] filt, logic signed [13:0] corr);
            logic [11:0] ef;
            logic signed [13:0] ec;
            if (exp_filt.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result beat filt=%0d corr=%0d", filt, corr);
                return;
            end
            ef = exp_filt.pop_front();
            ec = exp_corr.pop_front();
            if (filt !== ef || corr !== ec) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: filt exp %0d got %0d, corr exp %0d got %0d",
                             ef, filt, ec, corr);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    mag_x = '0;
    logic signed [15:0]    mag_y = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [11:0]           filtered_heading;
    logic signed [13:0]    corrected_heading;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    heading_board board = new();
    bit  quiet = 1'b0;
    int  rx_hold = 0;
    int  idle_cycles = 0;

    compass_heading_correct_filter_core dut (.*);

    initial begin
        forever #(PERIOD / 2) clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Result side: random stalls, checked at the rising edge.
    always @(negedge clk) begin
        if (rx_hold > 0) begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end else begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                rx_hold <= gap_len();
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_result(filtered_heading, corrected_heading);
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mag_x    = x;
        mag_y    = y;
        do @(posedge clk); while (!in_ready);
        board.note_sample(x, y);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        in_valid     = 1'b0;
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        @(negedge clk);
        cfg_write_en = 1'b0;
        board.write_reg(idx, data);
    endtask

    // Lets every outstanding result drain before the settings change.
    task automatic settle();
        in_valid = 1'b0;
        while (board.exp_filt.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_offsets(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                               logic [31:0] d);
        write_reg(REG_OFS01, a);
        write_reg(REG_OFS23, b);
        write_reg(REG_OFS45, c);
        write_reg(REG_OFS67, d);
    endtask

    function automatic logic [31:0] small_pair();
        logic [15:0] lo, hi;
        lo = 16'($signed($urandom_range(0, 400)) - 200);
        hi = 16'($signed($urandom_range(0, 400)) - 200);
        return {hi, lo};
    endfunction

    task automatic random_samples(int n);
        logic signed [15:0] x, y;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
            x = 16'($urandom());
            y = 16'($urandom());
            case ($urandom_range(0, 9))
                0: x = '0;
                1: y = '0;
                2: y = ($urandom_range(0, 1)) ? x : -x;
                3: begin
                    x = 16'($signed($urandom_range(0, 64)) - 32);
                    y = 16'($signed($urandom_range(0, 64)) - 32);
                end
                default: ;
            endcase
            send_sample(x, y);
        end
        quiet = 1'b0;
    endtask

    // Stimulus in phases, one setting of offsets and gain per phase.
    initial begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: axes, diagonals, extremes and zero X.
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd100);
        send_sample(16'sd0, -16'sd100);
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32767, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd100, 16'sd100);
        send_sample(-16'sd100, -16'sd99);
        send_sample(16'sd1, -16'sd32768);
        send_sample(-16'sd1, 16'sd32767);
        random_samples(250);
        settle();

        // Small offsets, a write to an unused index, random gain.
        set_offsets(small_pair(), small_pair(), small_pair(), small_pair());
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(REG_GAIN, {16'($urandom()), 16'($urandom_range(1, 32767))});
        random_samples(330);
        settle();

        // Zero denominator in two sectors, gain of zero.
        set_offsets({16'sd450, 16'sd0}, {16'sd0, -16'sd450}, 32'h0, 32'h0);
        write_reg(REG_GAIN, 32'h0);
        send_sample(16'sd1000, -16'sd300);
        send_sample(-16'sd1000, 16'sd300);
        random_samples(300);
        settle();

        // Offsets at the limits drive the calibration into saturation.
        set_offsets(32'h8000_7FFF, 32'h7FFF_8000, 32'hFFFF_FFFF, 32'h8000_8000);
        write_reg(REG_GAIN, 32'h0000_FFFF);
        random_samples(300);
        settle();

        // Fully random offsets, gain above unity then back to unity.
        set_offsets($urandom(), $urandom(), $urandom(), $urandom());
        write_reg(REG_GAIN, 32'($urandom_range(32769, 65535)));
        random_samples(200);
        settle();
        set_offsets(32'h7FFF_7FFF, 32'h0, small_pair(), small_pair());
        write_reg(REG_GAIN, 32'(GAIN_RESET));
        random_samples(200);

        in_valid = 1'b0;
        while (board.exp_filt.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
